[hw/rtl/fsrw_pkg.sv]
// Shared types, codes and the DAC address table for the shift register writer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package fsrw_pkg;

  localparam int unsigned TargetW    = 4;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned StrobeW    = 3;
  localparam int unsigned JobBytes   = 4;
  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned BitCntW    = $clog2(BitsPerByte + 1);
  localparam int unsigned ByteIdxW   = $clog2(JobBytes);
  localparam int unsigned QueueDepthDflt = 2;

  // Target codes with their own framing; everything else is a DAC write
  localparam logic [TargetW-1:0] TGT_TEST  = 4'd0;
  localparam logic [TargetW-1:0] TGT_LEFT  = 4'd1;
  localparam logic [TargetW-1:0] TGT_RIGHT = 4'd2;
  localparam logic [TargetW-1:0] TGT_DAC_FIRST = 4'd3;
  localparam logic [TargetW-1:0] TGT_DAC_LAST  = 4'd10;

  localparam logic [ByteW-1:0] DAC_INACTIVE  = 8'hFF;
  localparam logic [ByteW-1:0] DAC_WRITE_CLR = 8'hFE;

  typedef enum logic [StrobeW-1:0] {
    STB_CLK_TEST = 3'd0,
    STB_CLK_COM  = 3'd1,
    STB_LAT_TEST = 3'd2,
    STB_LAT_L    = 3'd3,
    STB_LAT_R    = 3'd4,
    STB_LAT_DAC  = 3'd5,
    STB_LAT_COM  = 3'd6
  } strobe_t;

  // One classified request: up to four bytes, each closed by its latch
  typedef struct packed {
    logic [JobBytes-1:0][ByteW-1:0] bytes;
    strobe_t [JobBytes-1:0]         latch;
    strobe_t                        shift_clk;
    logic                           multi;
  } job_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } back_state_t;

  function automatic logic [ByteW-1:0] dac_address(input logic [TargetW-1:0] tgt);
    logic [ByteW-1:0] addr;
    begin
      unique case (tgt)
        4'd3:    addr = 8'hF9;
        4'd4:    addr = 8'hFB;
        4'd5:    addr = 8'hF5;
        4'd6:    addr = 8'hDD;
        4'd7:    addr = 8'hED;
        4'd8:    addr = 8'hEF;
        4'd9:    addr = 8'hF7;
        4'd10:   addr = 8'hDF;
        default: addr = DAC_INACTIVE;
      endcase
      return addr;
    end
  endfunction

endpackage

[hw/rtl/frontend_shift_register_writer_unit.sv]
// Top level of the analog front-end shift register writer.
// Depends on fsrw_pkg, fsrw_front, fsrw_queue and fsrw_back.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready, in_target, in_write_byte) takes one write
//   request per transfer. Output channel (out_valid/out_ready, out_data_bit,
//   out_strobe_res, out_last) gives one pin event per transfer; out_last marks
//   the final event of a request.
//   Test and left/right control targets yield 9 events (8 shift-clock bits,
//   MSB first, then a latch). DAC targets and unknown codes yield 36 events
//   (four bytes, each closed by its latch).
//   The front end classifies a request in the cycle it is accepted and pushes
//   it into a job queue (QUEUE_DEPTH entries); in_ready is low only while the
//   queue is full. The back end pulls a job in the cycle after its push at the
//   earliest and emits events into the output register; the first event passes
//   through the queue, the sequencer state and the output register. Throughput
//   is one event per cycle while the receiver takes events, paced by the
//   back-end bit sequencer. Consecutive jobs follow without a gap.
//   When the receiver stalls, the output register holds its event and the
//   sequencer waits; the queue keeps accepting until full.
//   Synchronous reset (rst_n low) empties the queue, idles the sequencer and
//   drops any event in the output register.
module frontend_shift_register_writer_unit #(
  parameter int unsigned QUEUE_DEPTH = fsrw_pkg::QueueDepthDflt
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fsrw_pkg::TargetW-1:0]  in_target,
  input  logic [fsrw_pkg::ByteW-1:0]    in_write_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_data_bit,
  output logic [fsrw_pkg::StrobeW-1:0]  out_strobe_res,
  output logic                          out_last
);
  import fsrw_pkg::*;

  job_t push_job, head_job;
  logic push, full, pop, head_valid;

  // Classify the request into bytes and strobes
  fsrw_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_target     (in_target),
    .in_write_byte (in_write_byte),
    .q_full        (full),
    .q_push        (push),
    .q_job         (push_job)
  );

  // Decouple acceptance from serialization
  fsrw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .q_valid  (head_valid),
    .q_job    (head_job)
  );

  // Shift out bits and latches, one event per cycle unless the output stalls
  fsrw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (head_valid),
    .q_job          (head_job),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_bit   (out_data_bit),
    .out_strobe_res (out_strobe_res),
    .out_last       (out_last)
  );

endmodule

[hw/rtl/fsrw_front.sv]
// Front end: takes requests and classifies them into byte/strobe jobs.
// Depends on fsrw_pkg; feeds fsrw_queue.
`timescale 1ns / 1ps

module fsrw_front (
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [fsrw_pkg::TargetW-1:0]  in_target,
  input  logic [fsrw_pkg::ByteW-1:0]    in_write_byte,
  input  logic                          q_full,
  output logic                          q_push,
  output fsrw_pkg::job_t                q_job
);
  import fsrw_pkg::*;

  logic [ByteW-1:0] addr;

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign addr     = dac_address(in_target);

  always_comb begin
    q_job = '0;
    q_job.shift_clk = STB_CLK_COM;
    priority if (in_target == TGT_TEST) begin
      q_job.bytes[0]  = in_write_byte;
      q_job.latch[0]  = STB_LAT_TEST;
      q_job.shift_clk = STB_CLK_TEST;
      q_job.multi     = 1'b0;
    end else if (in_target == TGT_LEFT) begin
      q_job.bytes[0] = in_write_byte;
      q_job.latch[0] = STB_LAT_L;
      q_job.multi    = 1'b0;
    end else if (in_target == TGT_RIGHT) begin
      q_job.bytes[0] = in_write_byte;
      q_job.latch[0] = STB_LAT_R;
      q_job.multi    = 1'b0;
    end else begin
      // DAC write, unknown codes included: address, value, deselect, idle
      q_job.bytes[0] = addr;
      q_job.latch[0] = STB_LAT_DAC;
      q_job.bytes[1] = in_write_byte;
      q_job.latch[1] = STB_LAT_COM;
      q_job.bytes[2] = addr & DAC_WRITE_CLR;
      q_job.latch[2] = STB_LAT_DAC;
      q_job.bytes[3] = DAC_INACTIVE;
      q_job.latch[3] = STB_LAT_DAC;
      q_job.multi    = 1'b1;
    end
  end

endmodule

[hw/rtl/fsrw_queue.sv]
// Short job queue between front and back end.
// Depends on fsrw_pkg for the job type.
`timescale 1ns / 1ps

module fsrw_queue #(
  parameter int unsigned DEPTH = fsrw_pkg::QueueDepthDflt
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fsrw_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output fsrw_pkg::job_t q_job
);
  import fsrw_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  job_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CntFull);
  assign q_valid = (cnt_r != '0);
  assign q_job   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntFull)
    else $error("queue count exceeds depth");

  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count missed a push");

  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with mismatched pointers");

endmodule

[hw/rtl/fsrw_back.sv]
// Back end: serializes one job a time into pin events through an output register.
// Depends on fsrw_pkg; pulls jobs from fsrw_queue.
`timescale 1ns / 1ps

module fsrw_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  fsrw_pkg::job_t                q_job,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_data_bit,
  output logic [fsrw_pkg::StrobeW-1:0]  out_strobe_res,
  output logic                          out_last
);
  import fsrw_pkg::*;

  localparam logic [BitCntW-1:0]  LatchSlot = BitCntW'(BitsPerByte);
  localparam logic [ByteIdxW-1:0] LastByte  = ByteIdxW'(JobBytes - 1);

  back_state_t          state_r, state_nxt;
  job_t                 job_r, job_nxt;
  logic [ByteW-1:0]     sh_r, sh_nxt;
  logic [BitCntW-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [ByteIdxW-1:0]  byte_idx_r, byte_idx_nxt;
  logic                 line_r, line_nxt;
  logic                 ov_r, ov_nxt;
  logic                 od_r, od_nxt;
  strobe_t              os_r, os_nxt;
  logic                 ol_r, ol_nxt;

  logic emit, is_latch, last_byte, fin;

  always_comb begin
    emit      = (state_r == BK_RUN) && (!ov_r || out_ready);
    is_latch  = (bit_cnt_r == LatchSlot);
    last_byte = !job_r.multi || (byte_idx_r == LastByte);
    fin       = emit && is_latch && last_byte;
    q_pop     = q_valid && ((state_r == BK_IDLE) || fin);

    state_nxt    = state_r;
    job_nxt      = job_r;
    sh_nxt       = sh_r;
    bit_cnt_nxt  = bit_cnt_r;
    byte_idx_nxt = byte_idx_r;
    line_nxt     = line_r;
    ov_nxt       = ov_r;
    od_nxt       = od_r;
    os_nxt       = os_r;
    ol_nxt       = ol_r;

    // Drain the output register when taken
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    if (emit) begin
      ov_nxt = 1'b1;
      ol_nxt = fin;
      if (is_latch) begin
        od_nxt       = line_r;
        os_nxt       = job_r.latch[byte_idx_r];
        byte_idx_nxt = byte_idx_r + 1'b1;
        sh_nxt       = job_r.bytes[byte_idx_nxt];
        bit_cnt_nxt  = '0;
      end else begin
        od_nxt      = sh_r[ByteW-1];
        os_nxt      = job_r.shift_clk;
        line_nxt    = sh_r[ByteW-1];
        sh_nxt      = {sh_r[ByteW-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
      end
      if (fin) begin
        state_nxt = BK_IDLE;
      end
    end

    if (q_pop) begin
      state_nxt    = BK_RUN;
      job_nxt      = q_job;
      sh_nxt       = q_job.bytes[0];
      bit_cnt_nxt  = '0;
      byte_idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      ov_r       <= 1'b0;
      bit_cnt_r  <= '0;
      byte_idx_r <= '0;
    end else begin
      state_r    <= state_nxt;
      ov_r       <= ov_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      byte_idx_r <= byte_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    sh_r   <= sh_nxt;
    line_r <= line_nxt;
    od_r   <= od_nxt;
    os_r   <= os_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_valid      = ov_r;
  assign out_data_bit   = od_r;
  assign out_strobe_res = os_r;
  assign out_last       = ol_r;

  a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_RUN) |-> (bit_cnt_r <= LatchSlot))
    else $error("bit counter past latch slot");

  a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == BK_RUN) && !job_r.multi) |-> (byte_idx_r == '0))
    else $error("single-byte job advanced past first byte");

  a_last_is_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && fin) |=> (ov_r && ol_r && (os_r != STB_CLK_TEST) && (os_r != STB_CLK_COM)))
    else $error("final event is not a latch strobe");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_IDLE) |-> !emit)
    else $error("event emitted while idle");

endmodule
